[rtl/core/sgpe_pkg.sv]
// Shared types and constants for the scaled glyph point expander.
package sgpe_pkg;

    localparam int MAX_SCALE = 5;
    localparam logic [2:0] FLIP_ROW = 3'd7;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SCALE       = 3'd0;
    localparam logic [2:0] CFG_FILL_COUNT  = 3'd1;
    localparam logic [2:0] CFG_CLIP_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_CLIP_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_FORE_COLOR  = 3'd4;
    localparam logic [2:0] CFG_BACK_COLOR  = 3'd5;

    // Configuration reset values.
    localparam logic [2:0]  RST_SCALE       = 3'd1;
    localparam logic [2:0]  RST_FILL_COUNT  = 3'd1;
    localparam logic [7:0]  RST_CLIP_WIDTH  = 8'd255;
    localparam logic [7:0]  RST_CLIP_HEIGHT = 8'd255;
    localparam logic [15:0] RST_FORE_COLOR  = 16'h0F00;
    localparam logic [15:0] RST_BACK_COLOR  = 16'h0FFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a new point
        logic step;   // advance to the next pixel
    } sgpe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic drop;   // captured point lies outside the clip extent
        logic last;   // current pixel is the final one of the point
    } sgpe_sts_t;

endpackage

[rtl/core/sgpe_ctrl.sv]
// Controller state machine that sequences capture, clip check and pixel emission.
module sgpe_ctrl
    import sgpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  sgpe_sts_t sts,
    output sgpe_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        cmd.load = in_valid && in_ready;
        cmd.step = out_valid && out_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.drop ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready && sts.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/sgpe_dp.sv]
// Datapath: configuration registers, point capture, sub-pixel counters and pixel fields.
module sgpe_dp
    import sgpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [7:0]  origin_x,
    input  logic [7:0]  origin_y,
    input  logic [2:0]  glyph_column,
    input  logic [2:0]  glyph_row,
    input  logic        font_bit,
    input  sgpe_cmd_t   cmd,
    output sgpe_sts_t   sts,
    output logic [7:0]  pixel_x,
    output logic [7:0]  pixel_y,
    output logic [15:0] pixel_color,
    output logic        last_pixel
);

    logic [2:0]  scale_reg;
    logic [2:0]  fill_count_reg;
    logic [7:0]  clip_width_reg;
    logic [7:0]  clip_height_reg;
    logic [15:0] fore_color_reg;
    logic [15:0] back_color_reg;

    logic [7:0] base_x_reg;
    logic [7:0] base_y_reg;
    logic       bit_reg;
    logic       drop_reg;
    logic [2:0] sub_x_reg;
    logic [2:0] sub_y_reg;

    logic [7:0] base_x_next;
    logic [7:0] base_y_next;
    logic       drop_next;
    logic [2:0] sub_x_next;
    logic [2:0] sub_y_next;

    logic [2:0] scale_eff;
    logic [2:0] scale_m1;
    logic [2:0] fill_eff;
    logic [5:0] col_prod;
    logic [5:0] row_prod;
    logic [5:0] flip_prod;
    logic       fore_hit;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg       <= RST_SCALE;
            fill_count_reg  <= RST_FILL_COUNT;
            clip_width_reg  <= RST_CLIP_WIDTH;
            clip_height_reg <= RST_CLIP_HEIGHT;
            fore_color_reg  <= RST_FORE_COLOR;
            back_color_reg  <= RST_BACK_COLOR;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCALE:       scale_reg       <= cfg_data[2:0];
                CFG_FILL_COUNT:  fill_count_reg  <= cfg_data[2:0];
                CFG_CLIP_WIDTH:  clip_width_reg  <= cfg_data[7:0];
                CFG_CLIP_HEIGHT: clip_height_reg <= cfg_data[7:0];
                CFG_FORE_COLOR:  fore_color_reg  <= cfg_data;
                CFG_BACK_COLOR:  back_color_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Clamp scale into one to the maximum, and the fill count into one to the scale.
    always_comb
    begin
        if (scale_reg == 3'd0)
        begin
            scale_eff = 3'd1;
        end
        else if (scale_reg > 3'(MAX_SCALE))
        begin
            scale_eff = 3'(MAX_SCALE);
        end
        else
        begin
            scale_eff = scale_reg;
        end

        if (fill_count_reg == 3'd0)
        begin
            fill_eff = 3'd1;
        end
        else if (fill_count_reg > scale_eff)
        begin
            fill_eff = scale_eff;
        end
        else
        begin
            fill_eff = fill_count_reg;
        end
    end

    assign scale_m1  = scale_eff - 3'd1;
    assign col_prod  = 6'(glyph_column) * 6'(scale_eff);
    assign row_prod  = 6'(glyph_row) * 6'(scale_eff);
    assign flip_prod = 6'(FLIP_ROW - glyph_row) * 6'(scale_eff);

    assign base_x_next = origin_x + {2'b00, col_prod};
    assign base_y_next = origin_y + {2'b00, flip_prod};
    assign drop_next   = ({2'b00, col_prod} > clip_width_reg)
                      || ({2'b00, row_prod} > clip_height_reg);

    // Column offset is the outer loop, row offset the inner.
    always_comb
    begin
        sub_x_next = sub_x_reg;
        sub_y_next = sub_y_reg;
        if (cmd.load)
        begin
            sub_x_next = 3'd0;
            sub_y_next = 3'd0;
        end
        else if (cmd.step)
        begin
            if (sub_y_reg == scale_m1)
            begin
                sub_y_next = 3'd0;
                sub_x_next = sub_x_reg + 3'd1;
            end
            else
            begin
                sub_y_next = sub_y_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_x_reg <= 3'd0;
            sub_y_reg <= 3'd0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            sub_x_reg <= sub_x_next;
            sub_y_reg <= sub_y_next;
            if (cmd.load)
            begin
                drop_reg <= drop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_x_reg <= base_x_next;
            base_y_reg <= base_y_next;
            bit_reg    <= font_bit;
        end
    end

    assign fore_hit = bit_reg && (sub_x_reg < fill_eff) && (sub_y_reg < fill_eff);

    assign pixel_x     = base_x_reg + {5'd0, sub_x_reg};
    assign pixel_y     = base_y_reg + {5'd0, sub_y_reg};
    assign pixel_color = fore_hit ? fore_color_reg : back_color_reg;
    assign last_pixel  = sts.last;

    always_comb
    begin
        sts.drop = drop_reg;
        sts.last = (sub_x_reg == scale_m1) && (sub_y_reg == scale_m1);
    end

endmodule

[rtl/core/scaled_glyph_point_expander_top.sv]
// Top level of the scaled glyph point expander: controller, datapath and checks.
//
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready  | origin_x, origin_y, glyph_column, glyph_row, font_bit
//  out     | output    | out_valid / out_ready| pixel_x, pixel_y, pixel_color, last_pixel
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A point is transferred in and then passes through the clip check state, then
// scale*scale pixels are output, one pixel per output transfer, counted by the
// single sub-pixel counter pair. A clipped point is dropped after the check and
// the block returns to idle without output.
// A stalled output holds the current pixel; no new point is taken until the last
// pixel of the current one is transferred. Reset restores the register defaults.
module scaled_glyph_point_expander_top
    import sgpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  origin_x,
    input  logic [7:0]  origin_y,
    input  logic [2:0]  glyph_column,
    input  logic [2:0]  glyph_row,
    input  logic        font_bit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pixel_x,
    output logic [7:0]  pixel_y,
    output logic [15:0] pixel_color,
    output logic        last_pixel
);

    sgpe_cmd_t cmd;
    sgpe_sts_t sts;

    assign cfg_ready = 1'b1;

    sgpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sgpe_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .glyph_column (glyph_column),
        .glyph_row    (glyph_row),
        .font_bit     (font_bit),
        .cmd          (cmd),
        .sts          (sts),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_color  (pixel_color),
        .last_pixel   (last_pixel)
    );

    // The clip check cycle always follows an input transfer.
    a_check_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!out_valid && !in_ready))
        else $error("output or input open in the cycle after an input transfer");

    // Input and output are never open together.
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a pixel is pending");

    // After the final pixel is transferred the block returns to idle.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_pixel) |=> (in_ready && !out_valid))
        else $error("block did not return to idle after the final pixel");

    // A pixel that is not the last is followed by another pixel.
    a_more_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_pixel) |=> out_valid)
        else $error("pixel stream ended before the final pixel");

endmodule

[dv/tb.sv]
// Self-checking testbench for the scaled glyph point expander top level.
`timescale 1ns / 1ps

module tb;
    import sgpe_pkg::*;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [2:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [2:0] CFG_UNUSED_7 = 3'd7;
    localparam int SETTLE_CYCLES = 32;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {RX_FREE, RX_PATTERN} rx_mode_t;

    typedef struct packed {
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [15:0] pixel_color;
        logic        last_pixel;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  origin_x = '0;
    logic [7:0]  origin_y = '0;
    logic [2:0]  glyph_column = '0;
    logic [2:0]  glyph_row = '0;
    logic        font_bit = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        last_pixel;

    // Copy of the block's register file.
    logic [2:0]  scale_r = RST_SCALE;
    logic [2:0]  fill_r = RST_FILL_COUNT;
    logic [7:0]  clip_w_r = RST_CLIP_WIDTH;
    logic [7:0]  clip_h_r = RST_CLIP_HEIGHT;
    logic [15:0] fore_r = RST_FORE_COLOR;
    logic [15:0] back_r = RST_BACK_COLOR;

    pixel_t   expected_pixels[$];
    int       mismatch_count = 0;
    rx_mode_t rx_mode = RX_FREE;
    int       hold_left = 0;
    bit       tx_gaps = 1'b1;
    int       burst_left = 0;

    always #2 clk = ~clk;

    scaled_glyph_point_expander_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .glyph_column (glyph_column),
        .glyph_row    (glyph_row),
        .font_bit     (font_bit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_color  (pixel_color),
        .last_pixel   (last_pixel)
    );

    // Queues the pixel writes that one accepted point must produce.
    function automatic void expand_point(input logic [7:0] ox, input logic [7:0] oy,
                                         input logic [2:0] col, input logic [2:0] row,
                                         input logic fg_bit);
        int     s;
        int     f;
        int     bx;
        int     by;
        pixel_t px;
        s = int'(scale_r);
        if (s < 1) s = 1;
        if (s > MAX_SCALE) s = MAX_SCALE;
        f = int'(fill_r);
        if (f < 1) f = 1;
        if (f > s) f = s;
        // The clip test uses the row before it is flipped.
        if (int'(col) * s > int'(clip_w_r) || int'(row) * s > int'(clip_h_r)) return;
        bx = int'(ox) + s * int'(col);
        by = int'(oy) + s * (int'(FLIP_ROW) - int'(row));
        for (int dx = 0; dx < s; dx++) begin
            for (int dy = 0; dy < s; dy++) begin
                px.pixel_x = 8'(bx + dx);
                px.pixel_y = 8'(by + dy);
                px.pixel_color = (fg_bit && dx < f && dy < f) ? fore_r : back_r;
                px.last_pixel = (dx == s - 1 && dy == s - 1);
                expected_pixels.push_back(px);
            end
        end
    endfunction

    // Leaves cfg_valid high so that back-to-back writes keep it up; cfg_release drops it.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SCALE:       scale_r = data[2:0];
            CFG_FILL_COUNT:  fill_r = data[2:0];
            CFG_CLIP_WIDTH:  clip_w_r = data[7:0];
            CFG_CLIP_HEIGHT: clip_h_r = data[7:0];
            CFG_FORE_COLOR:  fore_r = data;
            CFG_BACK_COLOR:  back_r = data;
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
    endtask

    // Sends one point; valid stays high inside a burst and drops for the gap after it.
    task automatic send_point(input logic [7:0] ox, input logic [7:0] oy,
                              input logic [2:0] col, input logic [2:0] row,
                              input logic fg_bit);
        in_valid <= 1'b1;
        origin_x <= ox;
        origin_y <= oy;
        glyph_column <= col;
        glyph_row <= row;
        font_bit <= fg_bit;
        do @(posedge clk); while (!in_ready);
        expand_point(ox, oy, col, row, fg_bit);
        if (tx_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_random_point();
        send_point(8'($urandom), 8'($urandom), 3'($urandom), 3'($urandom), 1'($urandom));
    endtask

    // Stops sending and waits until every pixel write has come back and the block is idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic randomize_settings();
        logic [7:0] cw;
        logic [7:0] ch;
        // Small clip extents drop many points, so they are kept to a share of the phases.
        cw = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
        ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
        write_reg(CFG_SCALE, {13'($urandom), 3'($urandom_range(0, 7))});
        write_reg(CFG_FILL_COUNT, {13'($urandom), 3'($urandom_range(0, 7))});
        write_reg(CFG_CLIP_WIDTH, {8'($urandom), cw});
        write_reg(CFG_CLIP_HEIGHT, {8'($urandom), ch});
        write_reg(CFG_FORE_COLOR, 16'($urandom));
        write_reg(CFG_BACK_COLOR, 16'($urandom));
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? CFG_UNUSED_6 : CFG_UNUSED_7, 16'($urandom));
        cfg_release();
    endtask

    task automatic test_reset_defaults();
        send_point(8'd0, 8'd0, 3'd0, 3'd0, 1'b0);
        send_point(8'd255, 8'd255, 3'd7, 3'd7, 1'b1);
        send_point(8'd128, 8'd64, 3'd5, 3'd3, 1'b1);
        send_point(8'h55, 8'hAA, 3'd6, 3'd0, 1'b0);
        settle();
    endtask

    task automatic test_scale_fill_limits();
        // Zero scale and zero fill both act as one.
        write_reg(CFG_SCALE, 16'd0);
        write_reg(CFG_FILL_COUNT, 16'd0);
        cfg_release();
        send_point(8'd10, 8'd20, 3'd2, 3'd4, 1'b1);
        settle();
        // Out-of-range scale saturates at the maximum; coordinates wrap past 255.
        write_reg(CFG_SCALE, 16'd7);
        write_reg(CFG_FILL_COUNT, 16'd7);
        cfg_release();
        send_point(8'd250, 8'd250, 3'd7, 3'd0, 1'b1);
        settle();
        write_reg(CFG_SCALE, 16'd5);
        write_reg(CFG_FILL_COUNT, 16'd3);
        write_reg(CFG_FORE_COLOR, 16'h0000);
        write_reg(CFG_BACK_COLOR, 16'hFFFF);
        cfg_release();
        send_point(8'd0, 8'd0, 3'd1, 3'd2, 1'b1);
        send_point(8'd0, 8'd0, 3'd1, 3'd2, 1'b0);
        settle();
        // A fill count above the scale is cut back to the scale.
        write_reg(CFG_SCALE, 16'd3);
        write_reg(CFG_FILL_COUNT, 16'd5);
        write_reg(CFG_FORE_COLOR, 16'hFFFF);
        write_reg(CFG_BACK_COLOR, 16'h0000);
        cfg_release();
        send_point(8'd100, 8'd30, 3'd4, 3'd6, 1'b1);
        settle();
        write_reg(CFG_SCALE, 16'd4);
        write_reg(CFG_FILL_COUNT, 16'd2);
        cfg_release();
        send_point(8'd33, 8'd77, 3'd3, 3'd5, 1'b1);
        settle();
    endtask

    task automatic test_clip_edges();
        write_reg(CFG_SCALE, 16'd2);
        write_reg(CFG_FILL_COUNT, 16'd1);
        write_reg(CFG_CLIP_WIDTH, 16'd0);
        write_reg(CFG_CLIP_HEIGHT, 16'd0);
        cfg_release();
        send_point(8'd5, 8'd5, 3'd0, 3'd0, 1'b1);
        send_point(8'd5, 8'd5, 3'd1, 3'd0, 1'b1);
        send_point(8'd5, 8'd5, 3'd0, 3'd1, 1'b1);
        settle();
        // A product equal to the extent still passes; one step more is dropped.
        write_reg(CFG_CLIP_WIDTH, 16'd10);
        write_reg(CFG_CLIP_HEIGHT, 16'd14);
        cfg_release();
        send_point(8'd40, 8'd40, 3'd5, 3'd7, 1'b1);
        send_point(8'd40, 8'd40, 3'd6, 3'd7, 1'b0);
        settle();
        write_reg(CFG_CLIP_HEIGHT, 16'd13);
        // Writes past the register list must leave every register as it was.
        write_reg(CFG_UNUSED_6, 16'hFFFF);
        write_reg(CFG_UNUSED_7, 16'hFFFF);
        cfg_release();
        send_point(8'd40, 8'd40, 3'd5, 3'd7, 1'b1);
        send_point(8'd40, 8'd40, 3'd5, 3'd6, 1'b1);
        settle();
        write_reg(CFG_CLIP_WIDTH, 16'd255);
        write_reg(CFG_CLIP_HEIGHT, 16'd255);
        cfg_release();
        send_point(8'd200, 8'd1, 3'd7, 3'd7, 1'b0);
        settle();
    endtask

    task automatic test_output_backpressure();
        write_reg(CFG_SCALE, 16'd5);
        write_reg(CFG_FILL_COUNT, 16'd4);
        cfg_release();
        rx_mode = RX_FREE;
        tx_gaps = 1'b0;
        // The receiver holds off long enough for the input to back up behind it.
        hold_left = 400;
        repeat (10) send_random_point();
        settle();
        tx_gaps = 1'b1;
    endtask

    task automatic test_random_points();
        for (int p = 0; p < 10; p++) begin
            randomize_settings();
            rx_mode = (p % 3 == 0) ? RX_FREE : RX_PATTERN;
            tx_gaps = (p % 4 != 1);
            burst_left = 0;
            repeat (50) send_random_point();
            settle();
        end
    endtask

    // Receiver: always ready, alternating runs of ready and stall of random length, or a counted hold.
    initial begin : receiver
        int  run;
        bit  ready_run;
        run = 0;
        ready_run = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (rx_mode == RX_FREE) begin
                out_ready <= 1'b1;
            end else begin
                if (run == 0) begin
                    ready_run = !ready_run;
                    run = ready_run ? $urandom_range(1, 12) : $urandom_range(1, 5);
                end
                out_ready <= ready_run;
                run--;
            end
        end
    end

    // Compares each output transfer with the oldest expected pixel write.
    initial begin : pixel_checker
        pixel_t got;
        pixel_t want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                got = {pixel_x, pixel_y, pixel_color, last_pixel};
                if (expected_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected pixel write: x=%0d y=%0d color=%h last=%b",
                                 got.pixel_x, got.pixel_y, got.pixel_color, got.last_pixel);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("pixel mismatch: expected x=%0d y=%0d color=%h last=%b, got x=%0d y=%0d color=%h last=%b",
                                     want.pixel_x, want.pixel_y, want.pixel_color,
                                     want.last_pixel, got.pixel_x, got.pixel_y,
                                     got.pixel_color, got.last_pixel);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #1_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin : main
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_scale_fill_limits();
        test_clip_edges();
        test_output_backpressure();
        test_random_points();
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
